// ===== hw/rtl/lwnl_pkg.sv =====
// ----------------------------------------------------------------------------
// lwnl_pkg
// shared constants, widths and the window descriptor for the neighbour list
// ----------------------------------------------------------------------------
package lwnl_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int MAX_RADIUS = 3;

    // configuration register widths
    localparam int SIDE_W  = 9;
    localparam int RAD_W   = 2;
    localparam int AGENT_W = 20;
    localparam int EDGE_W  = 24;

    // item field widths
    localparam int IDX_W = 16;
    localparam int ID_W  = 21;

    // derived widths
    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
    localparam int CELLS_W = 2 * SIDE_W;
    localparam int ROW_W   = IDX_W + 1;

    // divider: two quotient bits per cycle
    localparam int DIV_CYCLES = IDX_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // descriptor queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // stream and configuration port widths
    localparam int PAY_W       = 2 * ID_W + EDGE_W;
    localparam int TDATA_W     = ((PAY_W + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - PAY_W;
    localparam int TUSER_W     = 2;
    localparam int S_TDATA_W   = ((IDX_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = EDGE_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AGENT_BASE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_BASE   = 2'd3;

    // reset values
    localparam logic [SIDE_W-1:0]  SIDE_RESET   = 9'd20;
    localparam logic [RAD_W-1:0]   RADIUS_RESET = 2'd1;
    localparam logic [AGENT_W-1:0] AGENT_RESET  = '0;
    localparam logic [EDGE_W-1:0]  EDGE_RESET   = '0;

    // tuser bit positions
    localparam int TUSER_NB_VALID = 0;
    localparam int TUSER_OOR      = 1;

    typedef struct packed {
        logic               oor;
        logic [ID_W-1:0]    node_id;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] xe;
        logic [SIDE_W-1:0]  side;
        logic [CNT_W-1:0]   n_nbr;
    } desc_t;

endpackage

// ===== hw/rtl/lwnl_front.sv =====
// ----------------------------------------------------------------------------
// lwnl_front
// accepts node indexes, splits them into column and row and clips the window
// ----------------------------------------------------------------------------
module lwnl_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwnl_pkg::S_TDATA_W-1:0]  s_tdata,     // node_index
    input  logic [lwnl_pkg::SIDE_W-1:0]     side_cfg,
    input  logic [lwnl_pkg::RAD_W-1:0]      radius_cfg,
    input  logic [lwnl_pkg::AGENT_W-1:0]    agent_base,
    input  logic                            q_full,
    output logic                            q_push,
    output lwnl_pkg::desc_t                 q_desc
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_CLIP, F_PUSH} fstate_t;

    fstate_t                            state_reg;
    logic [lwnl_pkg::IDX_W-1:0]         quo_reg;
    logic [lwnl_pkg::COORD_W-1:0]       rem_reg;
    logic [lwnl_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lwnl_pkg::SIDE_W-1:0]        side_reg;
    logic [lwnl_pkg::RAD_W-1:0]         rad_reg;
    logic [lwnl_pkg::ID_W-1:0]          nid_reg;
    logic                               oor_reg;
    logic [lwnl_pkg::COORD_W-1:0]       ax_reg, ay_reg, x0_reg, y0_reg, xe_reg;
    logic [lwnl_pkg::SPAN_W-1:0]        w_reg, h_reg;

    logic [lwnl_pkg::IDX_W-1:0]         quo_next;
    logic [lwnl_pkg::COORD_W-1:0]       rem_next;
    logic [lwnl_pkg::SIDE_W-1:0]        side_eff;
    logic [lwnl_pkg::RAD_W-1:0]         rad_eff;
    logic [lwnl_pkg::CELLS_W-1:0]       cells;
    logic                               in_oor;
    logic                               accept;
    logic [lwnl_pkg::IDX_W-1:0]         idx_in;
    logic [lwnl_pkg::COORD_W-1:0]       ax, ay, x0, y0, xe, ye;
    logic [lwnl_pkg::SIDE_W-1:0]        x_hi, y_hi, side_m1;
    logic [lwnl_pkg::CNT_W-1:0]         n_nbr;

    assign idx_in   = s_tdata[lwnl_pkg::IDX_W-1:0];
    assign side_eff = (side_cfg > lwnl_pkg::SIDE_W'(lwnl_pkg::MAX_SIDE))
                    ? lwnl_pkg::SIDE_W'(lwnl_pkg::MAX_SIDE) : side_cfg;
    assign rad_eff  = (radius_cfg > lwnl_pkg::RAD_W'(lwnl_pkg::MAX_RADIUS))
                    ? lwnl_pkg::RAD_W'(lwnl_pkg::MAX_RADIUS) : radius_cfg;
    assign cells    = lwnl_pkg::CELLS_W'(side_eff) * lwnl_pkg::CELLS_W'(side_eff);
    assign in_oor   = (side_eff == '0) || (lwnl_pkg::CELLS_W'(idx_in) >= cells);
    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    // restoring divide, two quotient bits per cycle
    always_comb begin
        logic [lwnl_pkg::COORD_W-1:0] r;
        logic [lwnl_pkg::IDX_W-1:0]   q;
        logic [lwnl_pkg::SIDE_W-1:0]  trial;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++) begin
            trial = {r, q[lwnl_pkg::IDX_W-1]};
            q     = {q[lwnl_pkg::IDX_W-2:0], 1'b0};
            if (trial >= side_reg) begin
                r    = lwnl_pkg::COORD_W'(trial - side_reg);
                q[0] = 1'b1;
            end else begin
                r = trial[lwnl_pkg::COORD_W-1:0];
            end
        end
        rem_next = r;
        quo_next = q;
    end

    // window clipping
    assign ax      = rem_reg;
    assign ay      = quo_reg[lwnl_pkg::COORD_W-1:0];
    assign side_m1 = side_reg - lwnl_pkg::SIDE_W'(1);
    assign x0      = (ax > lwnl_pkg::COORD_W'(rad_reg)) ? ax - lwnl_pkg::COORD_W'(rad_reg) : '0;
    assign y0      = (ay > lwnl_pkg::COORD_W'(rad_reg)) ? ay - lwnl_pkg::COORD_W'(rad_reg) : '0;
    assign x_hi    = lwnl_pkg::SIDE_W'(ax) + lwnl_pkg::SIDE_W'(rad_reg);
    assign y_hi    = lwnl_pkg::SIDE_W'(ay) + lwnl_pkg::SIDE_W'(rad_reg);
    assign xe      = (x_hi > side_m1) ? side_m1[lwnl_pkg::COORD_W-1:0]
                                      : x_hi[lwnl_pkg::COORD_W-1:0];
    assign ye      = (y_hi > side_m1) ? side_m1[lwnl_pkg::COORD_W-1:0]
                                      : y_hi[lwnl_pkg::COORD_W-1:0];

    assign n_nbr = oor_reg ? '0
                 : lwnl_pkg::CNT_W'(lwnl_pkg::CNT_W'(w_reg) * lwnl_pkg::CNT_W'(h_reg)
                                    - lwnl_pkg::CNT_W'(1));

    always_comb begin
        q_desc.oor     = oor_reg;
        q_desc.node_id = nid_reg;
        q_desc.ax      = ax_reg;
        q_desc.ay      = ay_reg;
        q_desc.x0      = x0_reg;
        q_desc.y0      = y0_reg;
        q_desc.xe      = xe_reg;
        q_desc.side    = side_reg;
        q_desc.n_nbr   = n_nbr;
    end

    assign q_push = (state_reg == F_PUSH) && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        quo_reg  <= idx_in;
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        side_reg <= side_eff;
                        rad_reg  <= rad_eff;
                        nid_reg  <= lwnl_pkg::ID_W'(idx_in) + lwnl_pkg::ID_W'(agent_base);
                        oor_reg  <= in_oor;
                        state_reg <= in_oor ? F_PUSH : F_DIV;
                    end
                end
                F_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + lwnl_pkg::DIV_CNT_W'(1);
                    if (cnt_reg == lwnl_pkg::DIV_CNT_W'(lwnl_pkg::DIV_CYCLES - 1)) begin
                        state_reg <= F_CLIP;
                    end
                end
                F_CLIP: begin
                    ax_reg <= ax;
                    ay_reg <= ay;
                    x0_reg <= x0;
                    y0_reg <= y0;
                    xe_reg <= xe;
                    w_reg  <= lwnl_pkg::SPAN_W'(xe - x0) + lwnl_pkg::SPAN_W'(1);
                    h_reg  <= lwnl_pkg::SPAN_W'(ye - y0) + lwnl_pkg::SPAN_W'(1);
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lwnl_queue.sv =====
// ----------------------------------------------------------------------------
// lwnl_queue
// short descriptor queue between the front and back parts
// ----------------------------------------------------------------------------
module lwnl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lwnl_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output lwnl_pkg::desc_t pop_desc,
    output logic            empty
);

    lwnl_pkg::desc_t                mem_reg [lwnl_pkg::Q_DEPTH];
    logic [lwnl_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lwnl_pkg::Q_CNT_W-1:0]   count_reg;

    assign full     = (count_reg == lwnl_pkg::Q_CNT_W'(lwnl_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_desc = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + lwnl_pkg::Q_PTR_W'(1);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + lwnl_pkg::Q_PTR_W'(1);
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + lwnl_pkg::Q_CNT_W'(1);
                2'b01:   count_reg <= count_reg - lwnl_pkg::Q_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/lwnl_back.sv =====
// ----------------------------------------------------------------------------
// lwnl_back
// walks each clipped window, one neighbour word per cycle unless stalled or at the node
// ----------------------------------------------------------------------------
module lwnl_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  lwnl_pkg::desc_t                 q_desc,
    output logic                            q_pop,
    input  logic [lwnl_pkg::AGENT_W-1:0]    agent_base,
    input  logic                            edge_load,
    input  logic [lwnl_pkg::EDGE_W-1:0]     edge_base,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwnl_pkg::TDATA_W-1:0]    m_tdata,     // node_id, edge_position, neighbour_id
    output logic [lwnl_pkg::TUSER_W-1:0]    m_tuser,     // neighbour_valid, out_of_range
    output logic                            m_tlast
);

    typedef enum logic [1:0] {B_IDLE, B_SETUP, B_WALK, B_SINGLE} bstate_t;

    bstate_t                        state_reg;
    lwnl_pkg::desc_t                desc_reg;
    logic [lwnl_pkg::COORD_W-1:0]   x_reg, y_reg;
    logic [lwnl_pkg::ROW_W-1:0]     row_reg;
    logic [lwnl_pkg::IDX_W-1:0]     cur_idx_reg;
    logic [lwnl_pkg::CNT_W-1:0]     cnt_reg;
    logic [lwnl_pkg::EDGE_W-1:0]    edge_count_reg;
    logic                           m_tvalid_reg;
    logic [lwnl_pkg::TDATA_W-1:0]   m_tdata_reg;
    logic [lwnl_pkg::TUSER_W-1:0]   m_tuser_reg;
    logic                           m_tlast_reg;

    logic                           out_free;
    logic                           at_self;
    logic                           row_end;
    logic                           is_last;
    logic                           emit;
    logic                           node_done;
    logic [lwnl_pkg::ROW_W-1:0]     row_step;
    logic [lwnl_pkg::ROW_W-1:0]     setup_row;
    logic [lwnl_pkg::ID_W-1:0]      nb_id;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign at_self   = (x_reg == desc_reg.ax) && (y_reg == desc_reg.ay);
    assign row_end   = (x_reg == desc_reg.xe);
    assign is_last   = (cnt_reg == lwnl_pkg::CNT_W'(desc_reg.n_nbr - lwnl_pkg::CNT_W'(1)));
    assign emit      = out_free && (((state_reg == B_WALK) && !at_self)
                                    || (state_reg == B_SINGLE));
    assign node_done = (state_reg == B_WALK) && emit && is_last;
    assign row_step  = row_reg + lwnl_pkg::ROW_W'(desc_reg.side);
    assign setup_row = lwnl_pkg::ROW_W'(desc_reg.y0) * lwnl_pkg::ROW_W'(desc_reg.side)
                     + lwnl_pkg::ROW_W'(desc_reg.x0);
    assign nb_id     = lwnl_pkg::ID_W'(cur_idx_reg) + lwnl_pkg::ID_W'(agent_base);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            m_tvalid_reg   <= 1'b0;
            edge_count_reg <= lwnl_pkg::EDGE_RESET;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (edge_load) begin
                edge_count_reg <= edge_base;
            end else if (node_done) begin
                edge_count_reg <= edge_count_reg + lwnl_pkg::EDGE_W'(desc_reg.n_nbr);
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        desc_reg  <= q_desc;
                        state_reg <= B_SETUP;
                    end
                end
                B_SETUP: begin
                    row_reg     <= setup_row;
                    cur_idx_reg <= setup_row[lwnl_pkg::IDX_W-1:0];
                    x_reg       <= desc_reg.x0;
                    y_reg       <= desc_reg.y0;
                    cnt_reg     <= '0;
                    state_reg   <= (desc_reg.oor || desc_reg.n_nbr == '0) ? B_SINGLE : B_WALK;
                end
                B_WALK: begin
                    if (out_free) begin
                        if (!at_self) begin
                            m_tdata_reg  <= {{lwnl_pkg::PAD_W{1'b0}}, nb_id,
                                             edge_count_reg, desc_reg.node_id};
                            m_tuser_reg  <= 2'b01;
                            m_tlast_reg  <= is_last;
                            cnt_reg      <= cnt_reg + lwnl_pkg::CNT_W'(1);
                            if (is_last) begin
                                state_reg <= B_IDLE;
                            end
                        end
                        if (row_end) begin
                            x_reg       <= desc_reg.x0;
                            y_reg       <= y_reg + lwnl_pkg::COORD_W'(1);
                            row_reg     <= row_step;
                            cur_idx_reg <= row_step[lwnl_pkg::IDX_W-1:0];
                        end else begin
                            x_reg       <= x_reg + lwnl_pkg::COORD_W'(1);
                            cur_idx_reg <= cur_idx_reg + lwnl_pkg::IDX_W'(1);
                        end
                    end
                end
                B_SINGLE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {{lwnl_pkg::PAD_W{1'b0}}, {lwnl_pkg::ID_W{1'b0}},
                                         edge_count_reg, desc_reg.node_id};
                        m_tuser_reg  <= {desc_reg.oor, 1'b0};
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lattice_window_neighbour_list.sv =====
// ----------------------------------------------------------------------------
// lattice_window_neighbour_list
// compressed neighbour list builder for a square lattice
// ----------------------------------------------------------------------------
// flow: an accepted index is divided, the window clipped and a descriptor pushed;
//   the back part pops it, sets up and walks the window; a node outside the grid
//   skips divide and clip and yields a single word; divider and window walk
//   overlap through a 2-deep queue, so a new index can be divided while the
//   last window is still being walked
// reset: synchronous active low; side 20, radius 1, bases and edge count 0
module lattice_window_neighbour_list (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lwnl_pkg::S_TDATA_W-1:0]    s_tdata,     // node_index
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lwnl_pkg::TDATA_W-1:0]      m_tdata,     // node_id, edge_position, neighbour_id
    output logic [lwnl_pkg::TUSER_W-1:0]      m_tuser,     // neighbour_valid, out_of_range
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [lwnl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lwnl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [lwnl_pkg::SIDE_W-1:0]    side_reg;
    logic [lwnl_pkg::RAD_W-1:0]     radius_reg;
    logic [lwnl_pkg::AGENT_W-1:0]   agent_reg;
    logic                           edge_load;
    logic                           q_push, q_full, q_pop, q_empty;
    lwnl_pkg::desc_t                push_desc, pop_desc;

    assign edge_load = cfg_wr_en && (cfg_addr == lwnl_pkg::CFG_EDGE_BASE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg   <= lwnl_pkg::SIDE_RESET;
            radius_reg <= lwnl_pkg::RADIUS_RESET;
            agent_reg  <= lwnl_pkg::AGENT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lwnl_pkg::CFG_SIDE_LENGTH: side_reg   <= cfg_wdata[lwnl_pkg::SIDE_W-1:0];
                lwnl_pkg::CFG_RADIUS:      radius_reg <= cfg_wdata[lwnl_pkg::RAD_W-1:0];
                lwnl_pkg::CFG_AGENT_BASE:  agent_reg  <= cfg_wdata[lwnl_pkg::AGENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lwnl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .side_cfg   (side_reg),
        .radius_cfg (radius_reg),
        .agent_base (agent_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_desc     (push_desc)
    );

    lwnl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .empty     (q_empty)
    );

    lwnl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_desc     (pop_desc),
        .q_pop      (q_pop),
        .agent_base (agent_reg),
        .edge_load  (edge_load),
        .edge_base  (cfg_wdata[lwnl_pkg::EDGE_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // a word without a neighbour always closes its node
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[lwnl_pkg::TUSER_NB_VALID]) |-> m_tlast)
        else $error("word without neighbour not marked last");

    // out of range nodes never carry a neighbour
    a_oor_no_nb: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[lwnl_pkg::TUSER_OOR]) |-> !m_tuser[lwnl_pkg::TUSER_NB_VALID])
        else $error("out of range node with neighbour");

    // the node itself is never listed
    a_no_self: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[lwnl_pkg::TUSER_NB_VALID])
        |-> (m_tdata[2*lwnl_pkg::ID_W+lwnl_pkg::EDGE_W-1:lwnl_pkg::ID_W+lwnl_pkg::EDGE_W]
             != m_tdata[lwnl_pkg::ID_W-1:0]))
        else $error("node listed as its own neighbour");

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("descriptor queue overflow");

endmodule
